/* rtl/brms_pkg.sv */
package brms_pkg;

    // status word layout
    localparam logic [31:0] PSR_RESET    = 32'h0000_00D3;
    localparam logic [31:0] PSR_FIQ_MASK = 32'h0000_0040;
    localparam logic [31:0] PSR_IRQ_MASK = 32'h0000_0080;

    localparam int unsigned NUM_GR      = 16;
    localparam int unsigned NUM_SLOTS   = 6;
    localparam int unsigned NUM_FIQ_HI  = 5;
    localparam int unsigned FIQ_HI_BASE = 8;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_STATUS = 2'd2,
        OP_EXCEPT = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        SLOT_USR  = 3'd0,
        SLOT_FIQ  = 3'd1,
        SLOT_IRQ  = 3'd2,
        SLOT_SVC  = 3'd3,
        SLOT_ABT  = 3'd4,
        SLOT_UND  = 3'd5,
        SLOT_NONE = 3'd6
    } slot_t;

    typedef enum logic [2:0] {
        EXC_UND  = 3'd0,
        EXC_SWI  = 3'd1,
        EXC_FIQ  = 3'd2,
        EXC_IRQ  = 3'd3,
        EXC_PABT = 3'd4,
        EXC_DABT = 3'd5
    } exc_t;

    typedef struct packed {
        logic        valid;
        op_t         op;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
        logic [2:0]  exception_kind;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] status_word;
        logic [31:0] saved_status;
        logic        did_reset;
    } rsp_t;

    function automatic slot_t slot_of(input logic [4:0] m);
        slot_t s;
        case (m)
            5'h10:   s = SLOT_USR;
            5'h11:   s = SLOT_FIQ;
            5'h12:   s = SLOT_IRQ;
            5'h13:   s = SLOT_SVC;
            5'h17:   s = SLOT_ABT;
            5'h1B:   s = SLOT_UND;
            default: s = SLOT_NONE;
        endcase
        return s;
    endfunction

    function automatic logic [4:0] slot_code(input slot_t s);
        logic [4:0] c;
        case (s)
            SLOT_USR: c = 5'h10;
            SLOT_FIQ: c = 5'h11;
            SLOT_IRQ: c = 5'h12;
            SLOT_SVC: c = 5'h13;
            SLOT_ABT: c = 5'h17;
            SLOT_UND: c = 5'h1B;
            default:  c = 5'h13;
        endcase
        return c;
    endfunction

    function automatic logic exc_known(input logic [2:0] k);
        return (k <= 3'(EXC_DABT));
    endfunction

    function automatic slot_t exc_slot(input logic [2:0] k);
        slot_t s;
        case (k)
            EXC_UND:  s = SLOT_UND;
            EXC_SWI:  s = SLOT_SVC;
            EXC_FIQ:  s = SLOT_FIQ;
            EXC_IRQ:  s = SLOT_IRQ;
            EXC_PABT: s = SLOT_ABT;
            EXC_DABT: s = SLOT_ABT;
            default:  s = SLOT_SVC;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] exc_vector(input logic [2:0] k);
        logic [31:0] v;
        case (k)
            EXC_UND:  v = 32'h04;
            EXC_SWI:  v = 32'h08;
            EXC_FIQ:  v = 32'h1C;
            EXC_IRQ:  v = 32'h18;
            EXC_PABT: v = 32'h0C;
            EXC_DABT: v = 32'h10;
            default:  v = 32'h04;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] exc_ret(input logic [2:0] k);
        return (k == 3'(EXC_DABT)) ? 32'd8 : 32'd4;
    endfunction

endpackage

/* rtl/brms_core.sv */
module brms_core
    import brms_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    output rsp_t rsp
);

    logic [31:0] gr_reg    [NUM_GR];
    logic [31:0] gr_next   [NUM_GR];
    logic [31:0] status_reg;
    logic [31:0] status_next;

    // banked copies; contents undefined until first written
    logic [63:0] sl_bank_reg [NUM_SLOTS];   // {r14, r13} per mode slot
    logic [31:0] saved_reg   [NUM_SLOTS];
    logic [31:0] fiq_lo_reg  [NUM_FIQ_HI];  // r8..r12 outside FIQ
    logic [31:0] fiq_hi_reg  [NUM_FIQ_HI];  // r8..r12 of FIQ

    slot_t       cur;
    slot_t       nxt;
    slot_t       aft;
    logic        do_swap;
    logic        exc_take;
    logic        saved_wr;
    logic        fiq_hi_wr;
    logic        fiq_lo_wr;
    logic        did_reset;
    logic [31:0] rd;
    logic [31:0] psr;
    logic [63:0] sl_rd;

    always_comb
    begin
        cur = slot_of(status_reg[4:0]);
        if (cur == SLOT_NONE)
        begin
            cur = SLOT_SVC;
        end
        nxt         = cur;
        gr_next     = gr_reg;
        status_next = status_reg;
        rd          = '0;
        did_reset   = 1'b0;
        do_swap     = 1'b0;
        exc_take    = 1'b0;
        saved_wr    = 1'b0;
        psr         = '0;

        if (req.valid)
        begin
            case (req.op)
                OP_READ:
                begin
                    rd = gr_reg[req.reg_index];
                end
                OP_WRITE:
                begin
                    gr_next[req.reg_index] = req.write_data;
                end
                OP_STATUS:
                begin
                    nxt = slot_of(req.write_data[4:0]);
                    if (nxt == SLOT_NONE)
                    begin
                        for (int i = 0; i < NUM_GR; i++)
                        begin
                            gr_next[i] = '0;
                        end
                        status_next = PSR_RESET;
                        did_reset   = 1'b1;
                    end
                    else
                    begin
                        do_swap     = (nxt != cur);
                        saved_wr    = (nxt != cur);
                        status_next = req.write_data;
                    end
                end
                OP_EXCEPT:
                begin
                    if (exc_known(req.exception_kind))
                    begin
                        nxt = exc_slot(req.exception_kind);
                        psr = status_reg | PSR_IRQ_MASK;
                        if (req.exception_kind == 3'(EXC_FIQ))
                        begin
                            psr = psr | PSR_FIQ_MASK;
                        end
                        psr[4:0]    = slot_code(nxt);
                        do_swap     = (nxt != cur);
                        saved_wr    = 1'b1;
                        exc_take    = 1'b1;
                        status_next = psr;
                    end
                end
                default:
                begin
                end
            endcase
        end

        fiq_hi_wr = do_swap && (cur == SLOT_FIQ);
        fiq_lo_wr = do_swap && (cur != SLOT_FIQ) && (nxt == SLOT_FIQ);

        // r13/r14 from the incoming mode's bank
        sl_rd = sl_bank_reg[nxt];
        if (do_swap)
        begin
            gr_next[13] = sl_rd[31:0];
            gr_next[14] = sl_rd[63:32];
        end
        for (int i = 0; i < NUM_FIQ_HI; i++)
        begin
            if (fiq_hi_wr)
            begin
                gr_next[FIQ_HI_BASE + i] = fiq_lo_reg[i];
            end
            else if (fiq_lo_wr)
            begin
                gr_next[FIQ_HI_BASE + i] = fiq_hi_reg[i];
            end
        end

        // link and vector go in after the swap
        if (exc_take)
        begin
            gr_next[14] = gr_reg[15] + exc_ret(req.exception_kind);
            gr_next[15] = exc_vector(req.exception_kind) - 32'd4;
        end

        aft = slot_of(status_next[4:0]);
        if (aft == SLOT_NONE)
        begin
            aft = SLOT_SVC;
        end

        rsp.read_data    = rd;
        rsp.status_word  = status_next;
        rsp.saved_status = saved_wr ? status_reg : saved_reg[aft];
        rsp.did_reset    = did_reset;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_GR; i++)
            begin
                gr_reg[i] <= '0;
            end
            status_reg <= PSR_RESET;
        end
        else
        begin
            gr_reg     <= gr_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_swap)
        begin
            sl_bank_reg[cur] <= {gr_reg[14], gr_reg[13]};
        end
        if (saved_wr)
        begin
            saved_reg[nxt] <= status_reg;
        end
        for (int i = 0; i < NUM_FIQ_HI; i++)
        begin
            if (fiq_hi_wr)
            begin
                fiq_hi_reg[i] <= gr_reg[FIQ_HI_BASE + i];
            end
            if (fiq_lo_wr)
            begin
                fiq_lo_reg[i] <= gr_reg[FIQ_HI_BASE + i];
            end
        end
    end

endmodule

/* rtl/banked_register_mode_switch.sv */
// A start transfer passes through the input register and then the result register before the done strobe.
// Throughput: one transfer per cycle; busy is held low, the core finishes each item in one pass.
// Each result is shown for exactly one cycle with done high; the receiver cannot stall.
// Reset (rst_n low, asynchronous): r0..r15 cleared, status word 0xD3 (supervisor,
// IRQ and FIQ masked), pipeline emptied. Banked copies are left as they are.
module banked_register_mode_switch
    import brms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [3:0]  reg_index,
    input  logic [31:0] write_data,
    input  logic [2:0]  exception_kind,
    output logic        done,
    output logic [31:0] read_data,
    output logic [31:0] status_word,
    output logic [31:0] saved_status,
    output logic        did_reset
);

    // Input register: one captured transfer. The core reads its state with the
    // item here, so the item ahead has always committed its updates by then.
    logic        in_valid_reg;
    logic [1:0]  mode_reg;
    logic [3:0]  reg_index_reg;
    logic [31:0] write_data_reg;
    logic [2:0]  exception_kind_reg;

    // Result register
    logic        done_reg;
    rsp_t        rsp_reg;

    req_t        req;
    rsp_t        rsp;
    logic        accept;

    // every cycle can take a transfer
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
            done_reg     <= in_valid_reg;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg           <= mode;
            reg_index_reg      <= reg_index;
            write_data_reg     <= write_data;
            exception_kind_reg <= exception_kind;
        end
        if (in_valid_reg)
        begin
            rsp_reg <= rsp;
        end
    end

    always_comb
    begin
        req.valid          = in_valid_reg;
        req.op             = op_t'(mode_reg);
        req.reg_index      = reg_index_reg;
        req.write_data     = write_data_reg;
        req.exception_kind = exception_kind_reg;
    end

    // register file, status word, banks and the mode-change logic
    brms_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign done         = done_reg;
    assign read_data    = rsp_reg.read_data;
    assign status_word  = rsp_reg.status_word;
    assign saved_status = rsp_reg.saved_status;
    assign did_reset    = rsp_reg.did_reset;

endmodule

/* rtl/brms_checker.sv */
module brms_checker
    import brms_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  mode,
    input logic [2:0]  exception_kind,
    input logic        done,
    input logic [31:0] read_data,
    input logic [31:0] status_word,
    input logic        did_reset
);

    // every transfer gives one result, through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("result missing two cycles after transfer");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without a transfer");

    a_reset_state: assert property (@(posedge clk) disable iff (!rst_n)
        (done && did_reset) |-> (status_word == PSR_RESET))
        else $error("forced reset did not give the reset status word");

    a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(mode, 2) != 2'(OP_READ))) |-> (read_data == '0))
        else $error("read data not zero for a non-read");

    a_exc_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(mode, 2) == 2'(OP_EXCEPT)) && exc_known($past(exception_kind, 2)))
        |-> ((status_word & PSR_IRQ_MASK) != '0))
        else $error("exception entry left IRQ unmasked");

endmodule

bind banked_register_mode_switch brms_checker u_brms_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .exception_kind (exception_kind),
    .done           (done),
    .read_data      (read_data),
    .status_word    (status_word),
    .did_reset      (did_reset)
);
